### hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int unsigned CP_W    = 21;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	// one code point to encode, with the end-of-stream mark for its last byte
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            last;
	} job_t;

	// queue status seen by its producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### hdl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Pairs input bytes into code units, tracks surrogates and pushes
// code points into the job queue.
// ----------------------------------------------------------------------------
module u16u8_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_byte,
	input  logic             end_of_stream,
	input  u16u8_pkg::q_status_t q_stat,
	output logic             push,
	output u16u8_pkg::job_t  push_job
);
	import u16u8_pkg::*;

	logic       big_endian_q;
	logic       byte_waiting_q;
	logic [7:0] first_byte_q;
	logic       high_waiting_q;
	logic [9:0] high_bits_q;
	logic       pend_valid_q;
	job_t       pend_job_q;

	logic        accept;
	logic [15:0] unit;
	logic        unit_hi, unit_lo;
	logic        job_a_v, job_b_v;
	job_t        job_a, job_b;
	job_t        held_job;
	logic        next_bw, next_hw;
	logic        load_first, load_high;

	assign in_stall = pend_valid_q || q_stat.full;
	assign accept   = in_valid && !in_stall;

	assign unit    = big_endian_q ? {first_byte_q, in_byte} : {in_byte, first_byte_q};
	assign unit_hi = (unit >= HI_SURR_MIN) && (unit <= HI_SURR_MAX);
	assign unit_lo = (unit >= LO_SURR_MIN) && (unit <= LO_SURR_MAX);

	always_comb begin
		held_job.cp   = CP_W'({6'h36, high_bits_q});
		held_job.last = 1'b0;
		job_a_v    = 1'b0;
		job_b_v    = 1'b0;
		job_a      = held_job;
		job_b.cp   = CP_W'(unit);
		job_b.last = end_of_stream;
		next_bw    = byte_waiting_q;
		next_hw    = high_waiting_q;
		load_first = 1'b0;
		load_high  = 1'b0;
		if (!byte_waiting_q) begin
			if (end_of_stream) begin
				// odd trailing byte is dropped; held high surrogate flushed
				job_a_v       = high_waiting_q;
				job_a.last    = 1'b1;
			end else begin
				next_bw    = 1'b1;
				load_first = 1'b1;
			end
		end else begin
			next_bw = 1'b0;
			if (high_waiting_q && unit_lo) begin
				job_a_v    = 1'b1;
				job_a.cp   = SUPP_BASE + {1'b0, high_bits_q, unit[9:0]};
				job_a.last = end_of_stream;
				next_hw    = 1'b0;
			end else if (high_waiting_q) begin
				job_a_v = 1'b1;
				if (unit_hi && !end_of_stream) begin
					next_hw   = 1'b1;
					load_high = 1'b1;
				end else begin
					next_hw = 1'b0;
					job_b_v = 1'b1;
				end
			end else if (unit_hi && !end_of_stream) begin
				next_hw   = 1'b1;
				load_high = 1'b1;
			end else begin
				job_a_v = 1'b1;
				job_a   = job_b;
			end
		end
		if (end_of_stream) begin
			next_bw = 1'b0;
			next_hw = 1'b0;
		end
	end

	// second job of a code unit waits in the pending slot until the queue has room
	assign push     = pend_valid_q ? !q_stat.full : (accept && job_a_v);
	assign push_job = pend_valid_q ? pend_job_q : job_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q   <= 1'b0;
			byte_waiting_q <= 1'b0;
			high_waiting_q <= 1'b0;
			pend_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) big_endian_q <= cfg_wdata;
			if (accept) begin
				byte_waiting_q <= next_bw;
				high_waiting_q <= next_hw;
				pend_valid_q   <= job_b_v;
			end else if (pend_valid_q && !q_stat.full) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && load_first) first_byte_q <= in_byte;
		if (accept && load_high)  high_bits_q  <= unit[9:0];
		if (accept && job_b_v)    pend_job_q   <= job_b;
	end

endmodule

### hdl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Small job FIFO between the front and the serializer.
// ----------------------------------------------------------------------------
module u16u8_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  u16u8_pkg::job_t       push_job,
	input  logic                  pop,
	output u16u8_pkg::job_t       head,
	output u16u8_pkg::q_status_t  stat
);
	import u16u8_pkg::*;

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	assign stat.full  = (count_q == Q_CW'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

### hdl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes the code point at the queue head into UTF-8 bytes, one per
// cycle while out_stall is low, into the output register.
// ----------------------------------------------------------------------------
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u16u8_pkg::job_t      head,
	input  u16u8_pkg::q_status_t q_stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 last_out
);
	import u16u8_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_out_q;
	logic [1:0] idx_q;

	logic [1:0] len_m1;
	logic [7:0] enc_byte;
	logic       load, final_byte;
	logic [CP_W-1:0] cp;

	assign cp = head.cp;

	always_comb begin
		if (cp < CP_W'(32'h80))         len_m1 = 2'd0;
		else if (cp < CP_W'(32'h800))   len_m1 = 2'd1;
		else if (cp < CP_W'(32'h10000)) len_m1 = 2'd2;
		else                            len_m1 = 2'd3;
	end

	always_comb begin
		enc_byte = 8'h00;
		case ({len_m1, idx_q})
			4'b00_00: enc_byte = {1'b0, cp[6:0]};
			4'b01_00: enc_byte = {3'b110, cp[10:6]};
			4'b01_01: enc_byte = {2'b10, cp[5:0]};
			4'b10_00: enc_byte = {4'b1110, cp[15:12]};
			4'b10_01: enc_byte = {2'b10, cp[11:6]};
			4'b10_10: enc_byte = {2'b10, cp[5:0]};
			4'b11_00: enc_byte = {5'b11110, cp[20:18]};
			4'b11_01: enc_byte = {2'b10, cp[17:12]};
			4'b11_10: enc_byte = {2'b10, cp[11:6]};
			4'b11_11: enc_byte = {2'b10, cp[5:0]};
			default:  enc_byte = 8'h00;
		endcase
	end

	assign load       = (!out_valid_q || !out_stall) && !q_stat.empty;
	assign final_byte = (idx_q == len_m1);
	assign pop        = load && final_byte;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_out  = last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= enc_byte;
			last_out_q <= head.last && final_byte;
		end
	end

endmodule

### hdl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 byte stream in, UTF-8 byte stream out.
// ----------------------------------------------------------------------------
// Input words carry one UTF-16 byte (in_byte) and end_of_stream; output
// words carry one UTF-8 byte (out_byte) and last_out, set on the final byte
// of a stream. Both channels use valid/stall; a word moves on an edge with
// valid high and stall low. cfg_we/cfg_wdata set the byte order (1 = big
// endian); the user writes them only while the block is idle (unchecked).
// The front pairs bytes and resolves surrogates, pushing code points into a
// four-entry queue; the serializer emits one UTF-8 byte per cycle, while
// out_stall is low, from the queue head into an output register.
// A completed code unit pushes its code point into the queue; its first
// UTF-8 byte then loads into the output register. Input takes one byte per
// cycle while the queue has room; sustained rate is set by the serializer,
// one output byte per cycle while out_stall is low (1 to 4 bytes per code
// point). A held high surrogate followed by a unit that is neither a low
// nor a new held high surrogate pushes two code points and stalls the input.
// Reset empties the queue, clears pairing/surrogate state and selects little
// endian. A stalled receiver holds the output register; the queue then fills
// and in_stall rises.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_out
);
	import u16u8_pkg::*;

	logic      push, pop;
	job_t      push_job, head;
	q_status_t q_stat;

	u16u8_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.q_stat        (q_stat),
		.push          (push),
		.push_job      (push_job)
	);

	u16u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last_out  (last_out)
	);

endmodule
